>>> design/bmi_pkg.sv
`default_nettype none
package bmi_pkg;
  localparam int unsigned ModulusBitsDef = 62;
  localparam int unsigned FieldW = 62;
  localparam logic [FieldW-1:0] ModulusReset = FieldW'(1);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StReduc = 8'b0000_0010,
    StGcd   = 8'b0000_0100,
    StDiv   = 8'b0000_1000,
    StRed   = 8'b0001_0000,
    StDone  = 8'b0010_0000,
    StRedQ  = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;
endpackage
`default_nettype wire

>>> design/binary_modular_inverse_core.sv
// channel   | dir | handshake              | payload
// s_axis    | in  | s_axis_tvalid/tready   | tdata[61:0] value
// m_axis    | out | m_axis_tvalid/tready   | tdata raw_coefficient, gcd, reduced_coefficient
//           |     |                        | (62 bits each, low first); tuser modulus_even
// cfg       | in  | cfg_valid_i/cfg_ready_o| cfg_data_i[61:0] modulus
// Steps per item from accept to a valid result: value mod b, the GCD loop, the quotient
// b/gcd, an optional reduction, then the output register. Even modulus: the core goes
// from the first step straight to output.
// One item is worked on at a time; s_axis_tready is low from accept to delivery.
// A stalled result holds in the output register. Reset sets the modulus to 1.
`default_nettype none
module binary_modular_inverse_core #(
  parameter int unsigned MODULUS_BITS = bmi_pkg::ModulusBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,   // [61:0] value
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [191:0]      m_axis_tdata,   // raw_coefficient, gcd, reduced_coefficient
  output logic [0:0]        m_axis_tuser,   // modulus_even
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [63:0]  cfg_data_i      // [61:0] modulus
);
  localparam int unsigned W = MODULUS_BITS;
  localparam int unsigned FW = bmi_pkg::FieldW;
  localparam int unsigned CW = $clog2(W + 1);

  bmi_pkg::state_e st_q, st_d;
  logic [FW-1:0] mod_q;
  logic [W-1:0]  b_q, d0_q, d1_q, x0_q, x1_q, q_q, red_q;
  logic [W-1:0]  dv_q, rem_q, quo_q, dsr_q;   // shared divider
  logic [CW-1:0] cnt_q;
  logic          even_q;
  logic [191:0]  out_q;

  assign s_axis_tready = (st_q == bmi_pkg::StIdle);
  assign cfg_ready_o   = (st_q == bmi_pkg::StIdle);
  assign m_axis_tvalid = (st_q == bmi_pkg::StOut);
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = even_q;

  // halving modulo b with an extra carry bit
  function automatic logic [W-1:0] halve(input logic [W:0] v, input logic [W-1:0] b);
    logic [W+1:0] s;
    s = v[0] ? ({1'b0, v} + {2'b00, b}) : {1'b0, v};
    return s[W:1];
  endfunction

  // divider step: shift one dividend bit into remainder
  logic [W:0] rsh, rsub;
  assign rsh  = {rem_q, dv_q[W-1]};
  assign rsub = rsh - {1'b0, dsr_q};

  // gcd step operands
  logic          swap;
  logic [W-1:0]  a0, a1, c0, c1, diff;
  logic [W:0]    xdiff;
  assign swap  = d0_q < d1_q;
  assign a0    = swap ? d1_q : d0_q;
  assign a1    = swap ? d0_q : d1_q;
  assign c0    = swap ? x1_q : x0_q;
  assign c1    = swap ? x0_q : x1_q;
  assign diff  = a0 - a1;
  assign xdiff = (c0 >= c1) ? ({1'b0, c0} - {1'b0, c1})
                            : ({1'b0, c0} + {1'b0, b_q} - {1'b0, c1});

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      bmi_pkg::StIdle:  if (s_axis_tvalid) st_d = bmi_pkg::StReduc;
      bmi_pkg::StReduc: if (even_q) st_d = bmi_pkg::StOut;
                        else if (cnt_q == CW'(W)) st_d = bmi_pkg::StGcd;
      bmi_pkg::StGcd:   if (d1_q == '0) st_d = bmi_pkg::StDiv;
      bmi_pkg::StDiv:   if (cnt_q == CW'(W)) st_d = bmi_pkg::StRed;
      bmi_pkg::StRed:   st_d = (x0_q > q_q) ? bmi_pkg::StRedQ : bmi_pkg::StDone;
      bmi_pkg::StRedQ:  if (cnt_q == CW'(W)) st_d = bmi_pkg::StDone;
      bmi_pkg::StDone:  st_d = bmi_pkg::StOut;
      bmi_pkg::StOut:   if (m_axis_tready) st_d = bmi_pkg::StIdle;
      default:          st_d = bmi_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= bmi_pkg::StIdle;
      mod_q <= bmi_pkg::ModulusReset;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) mod_q <= cfg_data_i[FW-1:0];
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      bmi_pkg::StIdle: begin
        b_q    <= mod_q[W-1:0];
        even_q <= ~mod_q[0];
        dv_q   <= s_axis_tdata[W-1:0];
        dsr_q  <= mod_q[W-1:0];
        rem_q  <= '0;
        cnt_q  <= '0;
        out_q  <= '0;
      end
      bmi_pkg::StReduc, bmi_pkg::StDiv, bmi_pkg::StRedQ: begin
        // restoring division, one bit per cycle
        if (cnt_q == CW'(W)) begin
          cnt_q <= '0;
          if (st_q == bmi_pkg::StReduc) begin
            d0_q <= b_q; d1_q <= rem_q; x0_q <= b_q; x1_q <= W'(1);
          end else if (st_q == bmi_pkg::StDiv) begin
            q_q <= quo_q;
          end else begin
            red_q <= rem_q + W'(1);
          end
        end else begin
          cnt_q <= cnt_q + CW'(1);
          dv_q  <= dv_q << 1;
          if (!rsub[W]) begin
            rem_q <= rsub[W-1:0]; quo_q <= {quo_q[W-2:0], 1'b1};
          end else begin
            rem_q <= rsh[W-1:0];  quo_q <= {quo_q[W-2:0], 1'b0};
          end
        end
      end
      bmi_pkg::StGcd: begin
        if (d1_q == '0) begin
          dv_q <= b_q; dsr_q <= d0_q; rem_q <= '0; cnt_q <= '0;
        end else if (!diff[0]) begin
          d0_q <= a1; d1_q <= diff >> 1;
          x0_q <= c1; x1_q <= halve(xdiff, b_q);
        end else if (!a0[0]) begin
          d0_q <= a0 >> 1; x0_q <= halve({1'b0, c0}, b_q);
          d1_q <= a1; x1_q <= c1;
        end else begin
          d0_q <= a0; x0_q <= c0;
          d1_q <= a1 >> 1; x1_q <= halve({1'b0, c1}, b_q);
        end
      end
      bmi_pkg::StRed: begin
        // (x-1) mod q + 1 when x > q, else x as is
        red_q <= x0_q;
        dv_q <= x0_q - W'(1); dsr_q <= q_q; rem_q <= '0; cnt_q <= '0;
      end
      bmi_pkg::StDone: begin
        out_q[FW-1:0]        <= FW'(x0_q);
        out_q[2*FW-1:FW]     <= FW'(d0_q);
        out_q[3*FW-1:2*FW]   <= FW'(red_q);
        out_q[191:3*FW]      <= '0;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
